// ----- rtl/core/normal_blend_toward_pivot_top_assert.svh -----
// Assertion macros for the normal blend block, clocked on clk and disabled in reset.
`ifndef NORMAL_BLEND_TOWARD_PIVOT_TOP_ASSERT_SVH
`define NORMAL_BLEND_TOWARD_PIVOT_TOP_ASSERT_SVH

// same-cycle implication
`define NBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/nbp_pkg.sv -----
// Shared constants, register codes and control structs of the normal blend block.
package nbp_pkg;

  localparam int NORMAL_COUNT = 4096;
  localparam int ID_W         = 12;
  localparam int ROW_BITS     = 32;
  localparam int ROW_W        = $clog2(ROW_BITS);
  localparam int ROWS         = NORMAL_COUNT / ROW_BITS;
  localparam int ROW_AW       = $clog2(ROWS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_RATIO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHARED_MODE = 3'd4;

  localparam logic signed [15:0] RATIO_RESET = 16'sd16384;
  localparam logic signed [16:0] ONE_Q14     = 17'sd16384;

  // width of a vector component fed to the normalise unit
  localparam int VEC_W = 41;
  localparam int MAG_W = VEC_W - 1;

  typedef struct packed {
    logic       in_take;
    logic       mark_wr;
    logic       unit_go;
    logic       unit_sel;   // 0: pivot direction, 1: blended sum
    logic       cap_dir;
    logic       blend_en;
    logic [1:0] blend_idx;
    logic       out_load;
    logic       out_skip;
  } ctrl_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic out_free;
    logic shared;
  } dp_stat_t;

endpackage

// ----- rtl/core/nbp_if.sv -----
// Valid/ready channel interfaces for input items and results.
interface nbp_in_if;
  logic               valid;
  logic               ready;
  logic               start_mesh;
  logic [11:0]        normal_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;

  modport source (output valid, start_mesh, normal_index, pos_x, pos_y, pos_z,
                  norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, start_mesh, normal_index, pos_x, pos_y, pos_z,
                norm_x, norm_y, norm_z, output ready);
endinterface

interface nbp_out_if;
  logic               valid;
  logic               ready;
  logic               skipped;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;

  modport source (output valid, skipped, out_x, out_y, out_z, input ready);
  modport sink (input valid, skipped, out_x, out_y, out_z, output ready);
endinterface

// ----- rtl/core/nbp_marks.sv -----
// Bitmap of processed normal ids: rows in memory, one valid flop per row.
module nbp_marks import nbp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            rd_en,
  input  logic [ID_W-1:0] rd_id,
  input  logic            wr_en,
  output logic            hit
);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]     row_valid;
  logic [ROW_BITS-1:0] rdata;
  logic [ID_W-1:0]     id_q;
  logic [ROW_AW-1:0]   row_q;
  logic [ROW_BITS-1:0] cur_row;
  logic [ROW_BITS-1:0] row_next;

  assign row_q = id_q[ID_W-1:ROW_W];

  // an invalid row reads as all clear
  always_comb begin
    cur_row  = row_valid[row_q] ? rdata : '0;
    row_next = cur_row;
    row_next[id_q[ROW_W-1:0]] = 1'b1;
  end

  assign hit = cur_row[id_q[ROW_W-1:0]];

  // memory port: read on transfer, write back in the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_id[ID_W-1:ROW_W]];
      id_q  <= rd_id;
    end
    if (wr_en) begin
      mem[row_q] <= row_next;
    end
  end

  // row valid flops, cleared at once by start of mesh
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (clear) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[row_q] <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/nbp_unit.sv -----
// Iterative unit-vector unit: scale, sum of squares, square root, divide.
module nbp_unit import nbp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [VEC_W-1:0] vin [3],
  output logic                    done,
  output logic signed [15:0]      q [3]
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_RSH  = 3'd1;
  localparam logic [2:0] U_LSH  = 3'd2;
  localparam logic [2:0] U_SQ   = 3'd3;
  localparam logic [2:0] U_SQRT = 3'd4;
  localparam logic [2:0] U_DLD  = 3'd5;
  localparam logic [2:0] U_DIV  = 3'd6;
  localparam logic [2:0] U_DONE = 3'd7;

  logic [2:0]       state;
  logic [MAG_W-1:0] mag [3];
  logic [2:0]       neg;
  logic [61:0]      ss;
  logic [61:0]      x;
  logic [61:0]      res;
  logic [61:0]      sbit;
  logic [4:0]       scnt;
  logic [1:0]       cidx;
  logic [31:0]      len;
  logic [47:0]      rem;
  logic [15:0]      quot;
  logic [3:0]       dcnt;

  logic             any_hi;
  logic             any_29;
  logic             all_zero;
  logic [59:0]      prod;
  logic [61:0]      t;
  logic             t_ok;
  logic [61:0]      res_next;
  logic [47:0]      trial;
  logic             d_ok;
  logic [15:0]      quot_next;
  logic [47:0]      num;

  always_comb begin
    any_hi   = 1'b0;
    any_29   = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_hi   = any_hi | (|mag[i][MAG_W-1:30]);
      any_29   = any_29 | mag[i][29];
      all_zero = all_zero & (mag[i] == '0);
    end
  end

  // one square per cycle, one root bit per cycle, one quotient bit per cycle
  assign prod     = mag[cidx][29:0] * mag[cidx][29:0];
  assign t        = res + sbit;
  assign t_ok     = x >= t;
  assign res_next = t_ok ? ((res >> 1) + sbit) : (res >> 1);
  assign trial    = {15'b0, len, 1'b0} << dcnt;
  assign d_ok     = rem >= trial;
  always_comb begin
    quot_next = quot;
    quot_next[dcnt] = d_ok;
  end
  assign num  = 48'({mag[cidx][29:0], 15'b0}) + 48'(len);
  assign done = state == U_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      case (state)
        U_IDLE: begin
          if (go) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vin[i][VEC_W-1];
              mag[i] <= vin[i][VEC_W-1] ? MAG_W'(-vin[i]) : vin[i][MAG_W-1:0];
            end
            state <= U_RSH;
          end
        end
        U_RSH: begin
          if (all_zero) begin
            for (int i = 0; i < 3; i++) q[i] <= '0;
            state <= U_DONE;
          end else if (any_hi) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            state <= U_LSH;
          end
        end
        U_LSH: begin
          if (!any_29) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            ss    <= '0;
            cidx  <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          ss   <= ss + 62'(prod);
          cidx <= cidx + 2'd1;
          if (cidx == 2'd2) begin
            x     <= ss + 62'(prod);
            res   <= '0;
            sbit  <= 62'(1) << 60;
            scnt  <= '0;
            state <= U_SQRT;
          end
        end
        U_SQRT: begin
          if (t_ok) x <= x - t;
          res  <= res_next;
          sbit <= sbit >> 2;
          scnt <= scnt + 5'd1;
          if (scnt == 5'd30) begin
            len   <= res_next[31:0];
            cidx  <= '0;
            state <= U_DLD;
          end
        end
        U_DLD: begin
          rem   <= num;
          quot  <= '0;
          dcnt  <= 4'd15;
          state <= U_DIV;
        end
        U_DIV: begin
          if (d_ok) rem <= rem - trial;
          quot <= quot_next;
          dcnt <= dcnt - 4'd1;
          if (dcnt == 4'd0) begin
            q[cidx] <= neg[cidx] ? -quot_next : quot_next;
            cidx    <= cidx + 2'd1;
            state   <= (cidx == 2'd2) ? U_DONE : U_DLD;
          end
        end
        U_DONE: begin
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/nbp_dp.sv -----
// Datapath: configuration, item registers, blend products and result register.
module nbp_dp import nbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic signed [15:0]    norm_x,
  input  logic signed [15:0]    norm_y,
  input  logic signed [15:0]    norm_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  skipped,
  output logic signed [15:0]    out_x,
  output logic signed [15:0]    out_y,
  output logic signed [15:0]    out_z
);

  logic signed [31:0]      pivot [3];
  logic signed [15:0]      ratio;
  logic                    shared;
  logic signed [31:0]      pos [3];
  logic signed [15:0]      nrm [3];
  logic signed [15:0]      du [3];
  logic signed [33:0]      s [3];
  logic signed [32:0]      d [3];
  logic signed [VEC_W-1:0] vin [3];
  logic signed [15:0]      uq [3];
  logic                    unit_done;
  logic signed [16:0]      ar;
  logic signed [16:0]      w;
  logic signed [32:0]      pn;
  logic signed [31:0]      pd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) pivot[i] <= '0;
      ratio  <= RATIO_RESET;
      shared <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIVOT_X:     pivot[0] <= cfg_data;
        REG_PIVOT_Y:     pivot[1] <= cfg_data;
        REG_PIVOT_Z:     pivot[2] <= cfg_data;
        REG_BLEND_RATIO: ratio    <= cfg_data[15:0];
        REG_SHARED_MODE: shared   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      pos[0] <= pos_x;
      pos[1] <= pos_y;
      pos[2] <= pos_z;
      nrm[0] <= norm_x;
      nrm[1] <= norm_y;
      nrm[2] <= norm_z;
    end
  end

  // pivot-to-vertex direction or blended sum into the unit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]   = {pos[i][31], pos[i]} - {pivot[i][31], pivot[i]};
      vin[i] = cmd.unit_sel ? VEC_W'(s[i]) : VEC_W'(d[i]);
    end
  end

  nbp_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.unit_go),
    .vin  (vin),
    .done (unit_done),
    .q    (uq)
  );

  // normal weight 1 - |r|, and one component's blend per cycle
  assign ar = ratio[15] ? -{ratio[15], ratio} : {ratio[15], ratio};
  assign w  = ONE_Q14 - ar;
  assign pn = nrm[cmd.blend_idx] * w;
  assign pd = du[cmd.blend_idx] * ratio;

  always_ff @(posedge clk) begin
    if (cmd.cap_dir) begin
      for (int i = 0; i < 3; i++) du[i] <= uq[i];
    end
    if (cmd.blend_en) begin
      s[cmd.blend_idx] <= 34'(pn) + 34'(pd);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      skipped <= cmd.out_skip;
      out_x   <= cmd.out_skip ? '0 : uq[0];
      out_y   <= cmd.out_skip ? '0 : uq[1];
      out_z   <= cmd.out_skip ? '0 : uq[2];
    end
  end

  assign stat.unit_done = unit_done;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.shared    = shared;

endmodule

// ----- rtl/core/nbp_ctrl.sv -----
// Controller: sequences mark check, direction, blend, renormalise and result.
module nbp_ctrl import nbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      mark_hit,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MARK  = 3'd1;
  localparam logic [2:0] S_DGO   = 3'd2;
  localparam logic [2:0] S_DWT   = 3'd3;
  localparam logic [2:0] S_BLEND = 3'd4;
  localparam logic [2:0] S_SGO   = 3'd5;
  localparam logic [2:0] S_SWT   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] bidx;
  logic       skip_q;
  logic       skip_now;

  assign in_ready = state == S_IDLE;
  assign skip_now = stat.shared && mark_hit;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    cmd.in_take   = in_ready && in_valid;
    cmd.blend_idx = bidx;
    cmd.out_skip  = skip_q;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MARK;
      S_MARK: begin
        cmd.mark_wr = stat.shared && !mark_hit;
        state_next  = skip_now ? S_FIN : S_DGO;
      end
      S_DGO: begin
        cmd.unit_go = 1'b1;
        state_next  = S_DWT;
      end
      S_DWT: begin
        if (stat.unit_done) begin
          cmd.cap_dir = 1'b1;
          state_next  = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd.blend_en = 1'b1;
        if (bidx == 2'd2) state_next = S_SGO;
      end
      S_SGO: begin
        cmd.unit_go  = 1'b1;
        cmd.unit_sel = 1'b1;
        state_next   = S_SWT;
      end
      S_SWT:   if (stat.unit_done) state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      bidx   <= '0;
      skip_q <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_MARK) skip_q <= skip_now;
      if (state == S_BLEND) begin
        bidx <= (bidx == 2'd2) ? 2'd0 : bidx + 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/normal_blend_toward_pivot_top.sv -----
// Top level of the normal blend block: channels, controller, datapath, marks.
//
// Use: face-vertex items arrive on in_ch (valid/ready); one result per item
// leaves on out_ch. An item transfers when valid and ready are both high.
// Configuration registers (pivot x/y/z, blend ratio, shared mode) are written
// through cfg_we/cfg_index/cfg_data while the block is idle.
// A skipped item goes from the mark check straight to the result state.
// A blended item runs the shared normalise unit twice; each pass scales the
// vector by shifts, sums the squares, takes the square root and divides each
// component (a pass ends early when its vector is zero), and its time is set
// by the bit-serial square root and the one-bit-a-cycle divider in that unit.
// One item is in work at a time; the next transfers as soon as the previous
// result is registered.
// Reset: control and configuration registers take their reset values and all
// processed marks clear at once through per-row valid flops; no clearing pass is needed.
// Stall: a result held in the output register waits for out_ch.ready; the
// block finishes the following item and then waits before loading it.
module normal_blend_toward_pivot_top import nbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  nbp_in_if.sink                in_ch,
  nbp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "normal_blend_toward_pivot_top_assert.svh"

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      mark_hit;

  nbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .mark_hit (mark_hit),
    .stat     (stat),
    .cmd      (cmd)
  );

  nbp_marks u_marks (
    .clk   (clk),
    .rst   (rst),
    .clear (cmd.in_take && in_ch.start_mesh),
    .rd_en (cmd.in_take),
    .rd_id (in_ch.normal_index),
    .wr_en (cmd.mark_wr),
    .hit   (mark_hit)
  );

  nbp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .pos_z     (in_ch.pos_z),
    .norm_x    (in_ch.norm_x),
    .norm_y    (in_ch.norm_y),
    .norm_z    (in_ch.norm_z),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .skipped   (out_ch.skipped),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_z     (out_ch.out_z)
  );

  // checks
  `NBP_ASSERT_NEXT(a_one_in_work, in_ch.valid && in_ch.ready, !in_ch.ready, "second item taken")
  `NBP_ASSERT_NOW(a_skip_zero, out_ch.valid && out_ch.skipped, (out_ch.out_x == 16'sd0) && (out_ch.out_y == 16'sd0) && (out_ch.out_z == 16'sd0), "skipped result not zero")
  `NBP_ASSERT_NOW(a_skip_shared, cmd.out_load && cmd.out_skip, stat.shared, "skip outside shared mode")

endmodule
